// ===== hdl/dspv_pkg.sv =====
// ----------------------------------------------------------------------------
// dspv_pkg
// Types and constants shared by the date string parser and its checker.
// ----------------------------------------------------------------------------
package dspv_pkg;

  typedef logic [13:0] dspv_value_t;
  typedef logic [3:0]  dspv_digits_t;

  typedef enum logic [3:0] {
    ERR_OK          = 4'd0,
    ERR_SEP_MISSING = 4'd1,
    ERR_NON_DIGIT   = 4'd2,
    ERR_YEAR_LEN    = 4'd3,
    ERR_YEAR_RANGE  = 4'd4,
    ERR_MONTH_LEN   = 4'd5,
    ERR_MONTH_RANGE = 4'd6,
    ERR_DAY_LEN     = 4'd7,
    ERR_DAY_RANGE   = 4'd8
  } dspv_err_t;

  localparam logic [1:0] ORD_MDY = 2'd0;
  localparam logic [1:0] ORD_DMY = 2'd1;

  localparam logic [2:0] REG_DATE_SEP    = 3'd0;
  localparam logic [2:0] REG_DATE_ORDER  = 3'd1;
  localparam logic [2:0] REG_MIN_YEAR    = 3'd2;
  localparam logic [2:0] REG_MAX_YEAR    = 3'd3;
  localparam logic [2:0] REG_YEAR_DIGITS = 3'd4;
  localparam logic [2:0] REG_MONTH_DIGITS = 3'd5;
  localparam logic [2:0] REG_DAY_DIGITS  = 3'd6;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam dspv_value_t  VALUE_MAX  = 14'h3FFF;
  localparam dspv_digits_t DIGITS_MAX = 4'hF;

  localparam dspv_value_t WIN_19_LOW  = 14'd80;
  localparam dspv_value_t WIN_19_HIGH = 14'd99;
  localparam dspv_value_t WIN_20_HIGH = 14'd79;
  localparam dspv_value_t YEAR_19XX   = 14'd1900;
  localparam dspv_value_t YEAR_20XX   = 14'd2000;

  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [4:0] DAYS_28   = 5'd28;
  localparam logic [4:0] DAYS_29   = 5'd29;
  localparam logic [4:0] DAYS_30   = 5'd30;
  localparam logic [4:0] DAYS_31   = 5'd31;

  localparam logic [7:0]  RST_DATE_SEP     = 8'd47;
  localparam logic [1:0]  RST_DATE_ORDER   = 2'd0;
  localparam logic [13:0] RST_MIN_YEAR     = 14'd1980;
  localparam logic [13:0] RST_MAX_YEAR     = 14'd2099;
  localparam logic [2:0]  RST_YEAR_DIGITS  = 3'd4;
  localparam logic [1:0]  RST_MONTH_DIGITS = 2'd2;
  localparam logic [1:0]  RST_DAY_DIGITS   = 2'd2;

endpackage

// ===== hdl/date_string_parser_validator.sv =====
// ----------------------------------------------------------------------------
// date_string_parser_validator
// Parses a date string one character per transaction and gives one verdict
// with year, month and day on the final character.
//
// Input channel (in_*): one character per transaction, in_last marks the end
// of the string. A character is taken whenever in_ready is high; each one
// updates the field accumulators (one multiply by ten and add) in the cycle
// it is taken. Result channel (out_*): one transaction per string. The final
// character's parsed fields go into the field latch, and the result register
// then registers the verdict from the range and calendar checks. Sustained
// rate is one character per cycle while the result channel does not stall.
// A stalled receiver holds the result register; a second final character
// waits in the field latch, and in_ready drops only when both are full.
// Configuration (APB): registers at byte addresses 4*i, to be written only
// while idle (the block does not enforce it), pready always high, reads
// return the register value. Reset (synchronous, rst_n low) clears the
// string state, empties both stages and loads the register reset values.
// ----------------------------------------------------------------------------
module date_string_parser_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  output logic [3:0]  out_error_cause,
  output logic [13:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dspv_pkg::*;

  logic [7:0]  date_sep_r;
  logic [1:0]  date_order_r;
  logic [13:0] min_year_r;
  logic [13:0] max_year_r;
  logic [2:0]  year_digits_r;
  logic [1:0]  month_digits_r;
  logic [1:0]  day_digits_r;

  logic [1:0]   field_index_r, field_index_nxt;
  dspv_value_t  field_value_r  [3];
  dspv_value_t  field_value_nxt [3];
  dspv_digits_t field_digits_r [3];
  dspv_digits_t field_digits_nxt [3];
  logic         non_digit_r, non_digit_nxt;

  logic         snap_v_r;
  logic [1:0]   snap_index_r;
  dspv_value_t  snap_value_r  [3];
  dspv_digits_t snap_digits_r [3];
  logic         snap_non_digit_r;

  logic        in_fire, adv, cfg_wr;
  logic [2:0]  reg_idx;
  logic [1:0]  fi;
  logic        is_sep, is_digit;
  dspv_value_t val_sel;
  logic [17:0] acc;

  logic [1:0]   yi, mi, di;
  dspv_value_t  yraw, yv, mv, dv;
  dspv_digits_t yd, md, dd;
  logic [4:0]   mdays;
  dspv_err_t    cause;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      date_sep_r     <= RST_DATE_SEP;
      date_order_r   <= RST_DATE_ORDER;
      min_year_r     <= RST_MIN_YEAR;
      max_year_r     <= RST_MAX_YEAR;
      year_digits_r  <= RST_YEAR_DIGITS;
      month_digits_r <= RST_MONTH_DIGITS;
      day_digits_r   <= RST_DAY_DIGITS;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DATE_SEP:     date_sep_r     <= pwdata[7:0];
        REG_DATE_ORDER:   date_order_r   <= pwdata[1:0];
        REG_MIN_YEAR:     min_year_r     <= pwdata[13:0];
        REG_MAX_YEAR:     max_year_r     <= pwdata[13:0];
        REG_YEAR_DIGITS:  year_digits_r  <= pwdata[2:0];
        REG_MONTH_DIGITS: month_digits_r <= pwdata[1:0];
        REG_DAY_DIGITS:   day_digits_r   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DATE_SEP:     prdata = {24'd0, date_sep_r};
      REG_DATE_ORDER:   prdata = {30'd0, date_order_r};
      REG_MIN_YEAR:     prdata = {18'd0, min_year_r};
      REG_MAX_YEAR:     prdata = {18'd0, max_year_r};
      REG_YEAR_DIGITS:  prdata = {29'd0, year_digits_r};
      REG_MONTH_DIGITS: prdata = {30'd0, month_digits_r};
      REG_DAY_DIGITS:   prdata = {30'd0, day_digits_r};
      default:          prdata = 32'd0;
    endcase
  end

  // Handshake
  assign adv      = !out_valid || out_ready;
  assign in_ready = !snap_v_r || adv;
  assign in_fire  = in_valid && in_ready;

  // Character step
  always_comb begin
    fi       = (field_index_r > 2'd2) ? 2'd2 : field_index_r;
    is_sep   = (in_char_code == date_sep_r) || (in_char_code == CHAR_SLASH) ||
               (in_char_code == CHAR_DASH) || (in_char_code == CHAR_DOT);
    is_digit = (in_char_code >= CHAR_ZERO) && (in_char_code <= CHAR_NINE);
    val_sel  = field_value_r[fi];
    acc      = ({4'd0, val_sel} << 3) + ({4'd0, val_sel} << 1) +
               {14'd0, in_char_code[3:0]};

    field_index_nxt  = field_index_r;
    field_value_nxt  = field_value_r;
    field_digits_nxt = field_digits_r;
    non_digit_nxt    = non_digit_r;

    if (is_sep && (fi < 2'd2)) begin
      field_index_nxt = fi + 2'd1;
    end else if (is_digit) begin
      field_value_nxt[fi] = (acc > {4'd0, VALUE_MAX}) ? VALUE_MAX : acc[13:0];
      if (field_digits_r[fi] < DIGITS_MAX) begin
        field_digits_nxt[fi] = field_digits_r[fi] + 4'd1;
      end
    end else begin
      non_digit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_index_r <= 2'd0;
      non_digit_r   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        field_value_r[i]  <= '0;
        field_digits_r[i] <= '0;
      end
    end else if (in_fire) begin
      if (in_last) begin
        field_index_r <= 2'd0;
        non_digit_r   <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          field_value_r[i]  <= '0;
          field_digits_r[i] <= '0;
        end
      end else begin
        field_index_r  <= field_index_nxt;
        non_digit_r    <= non_digit_nxt;
        field_value_r  <= field_value_nxt;
        field_digits_r <= field_digits_nxt;
      end
    end
  end

  // Field latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else if (in_fire && in_last) begin
      snap_v_r <= 1'b1;
    end else if (adv) begin
      snap_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last) begin
      snap_index_r     <= field_index_nxt;
      snap_non_digit_r <= non_digit_nxt;
      snap_value_r     <= field_value_nxt;
      snap_digits_r    <= field_digits_nxt;
    end
  end

  // Verdict
  always_comb begin
    unique case (date_order_r)
      ORD_MDY: begin mi = 2'd0; di = 2'd1; yi = 2'd2; end
      ORD_DMY: begin di = 2'd0; mi = 2'd1; yi = 2'd2; end
      default: begin yi = 2'd0; mi = 2'd1; di = 2'd2; end
    endcase

    yraw = snap_value_r[yi];
    mv   = snap_value_r[mi];
    dv   = snap_value_r[di];
    yd   = snap_digits_r[yi];
    md   = snap_digits_r[mi];
    dd   = snap_digits_r[di];

    priority if ((yraw <= WIN_19_HIGH) && (yraw >= WIN_19_LOW)) begin
      yv = yraw + YEAR_19XX;
    end else if (yraw <= WIN_20_HIGH) begin
      yv = yraw + YEAR_20XX;
    end else begin
      yv = yraw;
    end

    unique case (mv[3:0])
      4'd2:                      mdays = (yv[1:0] == 2'd0) ? DAYS_29 : DAYS_28;
      4'd4, 4'd6, 4'd9, 4'd11:   mdays = DAYS_30;
      default:                   mdays = DAYS_31;
    endcase

    priority if (snap_index_r < 2'd2) begin
      cause = ERR_SEP_MISSING;
    end else if (snap_non_digit_r) begin
      cause = ERR_NON_DIGIT;
    end else if ((yd > {1'b0, year_digits_r}) || (yd == 4'd0)) begin
      cause = ERR_YEAR_LEN;
    end else if ((yv > max_year_r) || (yv < min_year_r)) begin
      cause = ERR_YEAR_RANGE;
    end else if ((md > {2'b0, month_digits_r}) || (md == 4'd0)) begin
      cause = ERR_MONTH_LEN;
    end else if ((mv > {10'd0, MONTH_MAX}) || (mv == 14'd0)) begin
      cause = ERR_MONTH_RANGE;
    end else if ((dd > {2'b0, day_digits_r}) || (dd == 4'd0)) begin
      cause = ERR_DAY_LEN;
    end else if ((dv == 14'd0) || (dv > {9'd0, mdays})) begin
      cause = ERR_DAY_RANGE;
    end else begin
      cause = ERR_OK;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= snap_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && snap_v_r) begin
      out_valid_res   <= (cause == ERR_OK);
      out_error_cause <= cause;
      out_year        <= (cause == ERR_OK) ? yv : 14'd0;
      out_month       <= (cause == ERR_OK) ? mv[3:0] : 4'd0;
      out_day         <= (cause == ERR_OK) ? dv[4:0] : 5'd0;
    end
  end

endmodule

// ===== hdl/dspv_checker.sv =====
// ----------------------------------------------------------------------------
// dspv_checker
// Port-level checks on the date string parser, bound to its top level.
// ----------------------------------------------------------------------------
module dspv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_valid_res,
  input logic [3:0]  out_error_cause,
  input logic [13:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day
);
  import dspv_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_error_cause) &&
    $stable(out_year) && $stable(out_month) && $stable(out_day))
    else $error("stalled transaction changed");

  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_error_cause == ERR_OK &&
    out_month >= 4'd1 && out_month <= MONTH_MAX && out_day >= 5'd1 &&
    out_year != 14'd0)
    else $error("accepted date out of range");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_error_cause != ERR_OK &&
    out_year == 14'd0 && out_month == 4'd0 && out_day == 5'd0)
    else $error("rejected date carries fields");

endmodule

bind date_string_parser_validator dspv_checker u_dspv_checker (.*);
